// File: rtl/u8d_pkg.sv
package u8d_pkg;

  // Held sequence storage: a pending sequence keeps at most five bytes.
  localparam int unsigned HOLD_DEPTH = 5;
  localparam int unsigned HOLD_IDX_W = 3;

  // Byte classification constants.
  localparam logic [7:0] CONT_TAG_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG      = 8'h80;
  localparam logic [7:0] PAYLOAD_MASK  = 8'h3f;

  // One input word.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } u8d_in_t;

  // One result word.
  typedef struct packed {
    logic [30:0] code_point;
    logic [2:0]  unit_length;
    logic        stray_byte;
    logic        last_of_run;
  } u8d_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_TAIL
  } u8d_state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_RAW_IN,
    OP_LEAD_IN,
    OP_CONT_IN,
    OP_DONE_IN,
    OP_FLUSH_IN,
    OP_FLUSH_STEP,
    OP_FLUSH_END,
    OP_TAIL
  } u8d_op_t;

  // Command from controller to datapath.
  typedef struct packed {
    u8d_op_t op;
    logic    last;       // last result of the current input word
    logic    store_lead; // at flush end, keep the pending byte as a new lead
  } u8d_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic held_empty;
    logic is_cont;
    logic lead_single;
    logic completes;
    logic flush_last;
    logic slot_free;
    logic eot;
  } u8d_status_t;

  // Sequence length announced by a lead byte.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b inside {[8'hc0:8'hdf]}) begin
      len = 3'd2;
    end else if (b inside {[8'he0:8'hef]}) begin
      len = 3'd3;
    end else if (b inside {[8'hf0:8'hf7]}) begin
      len = 3'd4;
    end else if (b inside {[8'hf8:8'hfb]}) begin
      len = 3'd5;
    end else if (b inside {[8'hfc:8'hfd]}) begin
      len = 3'd6;
    end
    return len;
  endfunction

  // Payload bits a lead byte carries for a given sequence length.
  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    logic [7:0] m;
    case (len)
      3'd2:    m = 8'h1f;
      3'd3:    m = 8'h0f;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'hff;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/u8d_datapath.sv
module u8d_datapath
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  u8d_in_t     in_data,
  input  u8d_cmd_t    cmd,
  output u8d_status_t status,
  output logic        out_valid,
  input  logic        out_stall,
  output u8d_out_t    out_data
);

  logic [7:0]            held_r [HOLD_DEPTH];
  logic [HOLD_IDX_W-1:0] cnt_r;
  logic [2:0]            exp_r;
  logic [30:0]           cp_r;
  logic [HOLD_IDX_W-1:0] idx_r;
  logic [7:0]            pend_r;
  logic                  out_valid_r;
  u8d_out_t              out_data_r;

  logic [7:0]  in_byte;
  logic [7:0]  held_rd;
  logic [7:0]  lead_src;
  logic [2:0]  lead_src_len;
  logic [30:0] cp_ext;
  logic        load_out;
  u8d_out_t    out_nxt;

  assign in_byte = in_data.text_byte;
  assign held_rd = held_r[idx_r];

  // Status for the controller.
  always_comb begin
    status.held_empty  = (cnt_r == '0);
    status.is_cont     = ((in_byte & CONT_TAG_MASK) == CONT_TAG);
    status.lead_single = (lead_len(in_byte) == 3'd1);
    status.completes   = ({1'b0, cnt_r} + 4'd1) == {1'b0, exp_r};
    status.flush_last  = (idx_r == cnt_r - HOLD_IDX_W'(1));
    status.slot_free   = !out_valid_r || !out_stall;
    status.eot         = in_data.end_of_text;
  end

  // A new lead comes from the input, or from the pending byte after a flush.
  assign lead_src     = (cmd.op == OP_FLUSH_END) ? pend_r : in_byte;
  assign lead_src_len = lead_len(lead_src);
  assign cp_ext       = {cp_r[24:0], in_byte[5:0] & PAYLOAD_MASK[5:0]};

  // Result word selection.
  always_comb begin
    load_out = 1'b0;
    out_nxt  = out_data_r;
    case (cmd.op)
      OP_RAW_IN: begin
        load_out = 1'b1;
        out_nxt  = '{code_point: {23'd0, in_byte}, unit_length: 3'd1,
                     stray_byte: in_byte[7], last_of_run: 1'b1};
      end
      OP_DONE_IN: begin
        load_out = 1'b1;
        out_nxt  = '{code_point: cp_ext, unit_length: exp_r,
                     stray_byte: 1'b0, last_of_run: 1'b1};
      end
      OP_FLUSH_STEP, OP_FLUSH_END: begin
        load_out = 1'b1;
        out_nxt  = '{code_point: {23'd0, held_rd}, unit_length: 3'd1,
                     stray_byte: held_rd[7], last_of_run: cmd.last};
      end
      OP_TAIL: begin
        load_out = 1'b1;
        out_nxt  = '{code_point: {23'd0, pend_r}, unit_length: 3'd1,
                     stray_byte: pend_r[7], last_of_run: 1'b1};
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // Held sequence, accumulator and flush pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      exp_r <= '0;
      idx_r <= '0;
    end else begin
      case (cmd.op)
        OP_LEAD_IN: begin
          held_r[0] <= lead_src;
          cnt_r     <= HOLD_IDX_W'(1);
          exp_r     <= lead_src_len;
          cp_r      <= {23'd0, lead_src & lead_mask(lead_src_len)};
        end
        OP_CONT_IN: begin
          held_r[cnt_r] <= in_byte;
          cnt_r         <= cnt_r + HOLD_IDX_W'(1);
          cp_r          <= cp_ext;
        end
        OP_DONE_IN: begin
          cnt_r <= '0;
          exp_r <= '0;
        end
        OP_FLUSH_IN: begin
          pend_r <= in_byte;
          idx_r  <= '0;
        end
        OP_FLUSH_STEP: begin
          idx_r <= idx_r + HOLD_IDX_W'(1);
        end
        OP_FLUSH_END: begin
          idx_r <= '0;
          if (cmd.store_lead) begin
            held_r[0] <= lead_src;
            cnt_r     <= HOLD_IDX_W'(1);
            exp_r     <= lead_src_len;
            cp_r      <= {23'd0, lead_src & lead_mask(lead_src_len)};
          end else begin
            cnt_r <= '0;
            exp_r <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/u8d_ctrl.sv
module u8d_ctrl
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  u8d_status_t status,
  output u8d_cmd_t    cmd
);

  u8d_state_t state_r, state_nxt;
  logic       tail_emit_r, tail_emit_nxt;
  logic       accept;

  assign in_stall = !((state_r == ST_RUN) && status.slot_free);
  assign accept   = in_valid && !in_stall;

  // Next state and tail mode.
  always_comb begin
    state_nxt     = state_r;
    tail_emit_nxt = tail_emit_r;
    case (state_r)
      ST_RUN: begin
        if (accept && !status.held_empty) begin
          if (!status.is_cont) begin
            state_nxt     = ST_FLUSH;
            tail_emit_nxt = status.lead_single || status.eot;
          end else if (!status.completes && status.eot) begin
            state_nxt     = ST_FLUSH;
            tail_emit_nxt = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (status.slot_free && status.flush_last) begin
          state_nxt = tail_emit_r ? ST_TAIL : ST_RUN;
        end
      end
      ST_TAIL: begin
        if (status.slot_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '{op: OP_IDLE, last: 1'b0, store_lead: 1'b0};
    case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (status.held_empty) begin
            cmd.op = (status.lead_single || status.eot) ? OP_RAW_IN : OP_LEAD_IN;
          end else if (status.is_cont) begin
            if (status.completes) begin
              cmd.op = OP_DONE_IN;
            end else if (status.eot) begin
              cmd.op = OP_FLUSH_IN;
            end else begin
              cmd.op = OP_CONT_IN;
            end
          end else begin
            cmd.op = OP_FLUSH_IN;
          end
        end
      end
      ST_FLUSH: begin
        if (status.slot_free) begin
          if (status.flush_last) begin
            cmd.op         = OP_FLUSH_END;
            cmd.last       = !tail_emit_r;
            cmd.store_lead = !tail_emit_r;
          end else begin
            cmd.op = OP_FLUSH_STEP;
          end
        end
      end
      ST_TAIL: begin
        if (status.slot_free) begin
          cmd.op = OP_TAIL;
        end
      end
      default: begin
        cmd.op = OP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      tail_emit_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_emit_r <= tail_emit_nxt;
    end
  end

endmodule

// File: rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder, six-byte form, overlong sequences accepted.
// Input channel: in_valid / in_stall / in_data carry one text byte per word,
// with end_of_text marking the last byte available. Output channel:
// out_valid / out_stall / out_data carry one decoded unit per word; the
// last_of_run bit marks the final result caused by an input byte.
// A result is in the output register in the cycle after the byte that
// completes it is accepted.
// Throughput: one byte per cycle while sequences are well formed and the
// output is free. When a non-continuation byte ends a sequence early, or
// end_of_text cuts one short, in_stall is high while the held bytes are
// replayed from the hold registers, one per cycle while the output is free;
// then the tail byte comes out unless it leads a new sequence. A byte that
// only extends a pending sequence gives no result. The single output
// register sets the pace: while it holds a result that the receiver stalls,
// in_stall is high and no byte is taken. Reset (rst_n low, synchronous)
// drops any pending sequence and empties the output register.
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  u8d_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output u8d_out_t out_data
);

  u8d_cmd_t    cmd;
  u8d_status_t status;

  // Sequencing of accept, flush and tail steps.
  u8d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold registers, code point accumulator and output register.
  u8d_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import u8d_pkg::*;

  localparam int RANDOM_WORDS = 460;
  localparam int CLK_HALF_NS = 10;
  localparam longint LIMIT_NS = 64'd6_000_000;

  // One queued input word; drain_first holds it back until all units are out.
  typedef struct {
    u8d_in_t word;
    bit      drain_first;
  } pending_word_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  u8d_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  u8d_out_t out_data;

  pending_word_t text_q[$];
  u8d_out_t      unit_q[$];
  u8d_out_t      step_units[$];
  int            error_count = 0;

  // Mirror of the decoder's pending sequence.
  logic [7:0] seq_bytes [HOLD_DEPTH];
  int         seq_count = 0;
  int         seq_len = 0;

  // Sender pacing.
  int burst_left = 0;
  int gap_left = 0;

  // Receiver pacing.
  int stall_cycle = 0;

  utf8_stream_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Sequence length announced by a lead byte.
  function automatic int seq_length_of(logic [7:0] b);
    if (b < 8'hc0) return 1;
    if (b < 8'he0) return 2;
    if (b < 8'hf0) return 3;
    if (b < 8'hf8) return 4;
    if (b < 8'hfc) return 5;
    if (b < 8'hfe) return 6;
    return 1;
  endfunction

  // A byte that comes out alone as a unit of length one.
  function automatic u8d_out_t single_unit(logic [7:0] b);
    u8d_out_t u;
    u = '0;
    u.code_point = {23'd0, b};
    u.unit_length = 3'd1;
    u.stray_byte = b[7];
    return u;
  endfunction

  // Every held byte is released as a raw unit and the sequence is dropped.
  task automatic release_held();
    for (int i = 0; i < seq_count; i++) begin
      step_units.push_back(single_unit(seq_bytes[i]));
    end
    seq_count = 0;
    seq_len = 0;
  endtask

  // A byte taken as a new lead: either a unit by itself or the start of a sequence.
  task automatic open_sequence(logic [7:0] b, logic eot);
    int n;
    n = seq_length_of(b);
    if (n == 1) begin
      step_units.push_back(single_unit(b));
    end else begin
      seq_bytes[0] = b;
      seq_count = 1;
      seq_len = n;
      if (eot) begin
        release_held();
      end
    end
  endtask

  // Works out the units that one accepted text byte causes.
  task automatic decode_text_byte(u8d_in_t w);
    logic [7:0]  b;
    logic [30:0] cp;
    u8d_out_t    u;
    int          len;
    b = w.text_byte;
    step_units.delete();
    if (seq_count == 0) begin
      open_sequence(b, w.end_of_text);
    end else if ((b & CONT_TAG_MASK) == CONT_TAG) begin
      if (seq_count + 1 >= seq_len) begin
        len = seq_count + 1;
        cp = {23'd0, seq_bytes[0]} & ((31'd1 << (7 - len)) - 31'd1);
        for (int i = 1; i < seq_count; i++) begin
          cp = (cp << 6) | {25'd0, seq_bytes[i][5:0]};
        end
        cp = (cp << 6) | {25'd0, b[5:0]};
        u = '0;
        u.code_point = cp;
        u.unit_length = 3'(len);
        step_units.push_back(u);
        seq_count = 0;
        seq_len = 0;
      end else begin
        seq_bytes[seq_count] = b;
        seq_count++;
        if (w.end_of_text) begin
          release_held();
        end
      end
    end else begin
      release_held();
      open_sequence(b, w.end_of_text);
    end

    // The final unit of this byte carries the run marker.
    if (step_units.size() > 0) begin
      u = step_units.pop_back();
      u.last_of_run = 1'b1;
      step_units.push_back(u);
    end
    foreach (step_units[i]) begin
      unit_q.push_back(step_units[i]);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic add_word(logic [7:0] b, logic eot, bit drain);
    pending_word_t p;
    p.word.text_byte = b;
    p.word.end_of_text = eot;
    p.drain_first = drain;
    text_q.push_back(p);
  endtask

  // Sender: bursts of words with random gaps; a marked word waits for a full drain.
  always @(posedge clk) begin : sender
    pending_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (text_q.size() > 0 &&
                   (!text_q[0].drain_first || (!in_valid && unit_q.size() == 0))) begin
        nxt = text_q.pop_front();
        in_data <= nxt.word;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: free-flowing, random and heavy periodic stall phases in turn.
  always @(posedge clk) begin
    stall_cycle++;
    case ((stall_cycle / 300) % 3)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        out_stall <= ((stall_cycle % 13) < 9);
      end
    endcase
  end

  // Monitor: predicts on each accepted word and checks each accepted unit.
  always @(posedge clk) begin : monitor
    u8d_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_text_byte(in_data);
      end
      if (out_valid && !out_stall) begin
        if (unit_q.size() == 0) begin
          report_mismatch($sformatf("unexpected unit cp=%h len=%0d",
                                    out_data.code_point, out_data.unit_length));
        end else begin
          want = unit_q.pop_front();
          if (out_data.code_point !== want.code_point)
            report_mismatch($sformatf("code_point %h, want %h",
                                      out_data.code_point, want.code_point));
          if (out_data.unit_length !== want.unit_length)
            report_mismatch($sformatf("unit_length %0d, want %0d",
                                      out_data.unit_length, want.unit_length));
          if (out_data.stray_byte !== want.stray_byte)
            report_mismatch($sformatf("stray_byte %b, want %b",
                                      out_data.stray_byte, want.stray_byte));
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, want %b",
                                      out_data.last_of_run, want.last_of_run));
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int         kind;
    int         len;
    int         cut;
    int         added;
    logic [7:0] lead;
    logic [7:0] b;

    // Directed: single bytes at the edges of each range.
    add_word(8'h00, 1'b0, 1'b0);
    add_word(8'hff, 1'b1, 1'b0);
    add_word(8'h80, 1'b0, 1'b0);
    // Overlong two-byte zero, largest three-byte and largest six-byte forms.
    add_word(8'hc0, 1'b0, 1'b0);
    add_word(8'h80, 1'b0, 1'b0);
    add_word(8'hef, 1'b0, 1'b0);
    add_word(8'hbf, 1'b0, 1'b0);
    add_word(8'hbf, 1'b0, 1'b0);
    add_word(8'hfd, 1'b0, 1'b0);
    repeat (5) add_word(8'hbf, 1'b0, 1'b0);
    // A plain byte cuts a five-byte lead short.
    add_word(8'hf8, 1'b0, 1'b0);
    add_word(8'h41, 1'b0, 1'b0);
    // A new lead cuts a lead short, then end of text flushes a partial sequence.
    add_word(8'he0, 1'b0, 1'b0);
    add_word(8'he1, 1'b0, 1'b0);
    add_word(8'h80, 1'b1, 1'b0);
    // End of text on a lone lead byte.
    add_word(8'hf0, 1'b1, 1'b0);
    // Three held bytes released by a new lead, which a plain byte then releases.
    add_word(8'hf4, 1'b0, 1'b0);
    add_word(8'h8f, 1'b0, 1'b0);
    add_word(8'hbf, 1'b0, 1'b0);
    add_word(8'hc3, 1'b0, 1'b0);
    add_word(8'h7f, 1'b1, 1'b0);

    // Random: mostly well-formed sequences, some cut short, some noise bytes.
    added = 0;
    while (added < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        add_word(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0),
                 (added == 0) || ($urandom_range(0, 119) == 0));
        added++;
      end else begin
        len = $urandom_range(1, 6);
        case (len)
          1: begin
            if ($urandom_range(0, 3) == 0) begin
              lead = $urandom_range(0, 1) ? (8'hfe | 8'($urandom_range(0, 1)))
                                          : (8'h80 | 8'($urandom_range(0, 63)));
            end else begin
              lead = 8'($urandom_range(0, 127));
            end
          end
          2: lead = 8'hc0 | 8'($urandom_range(0, 31));
          3: lead = 8'he0 | 8'($urandom_range(0, 15));
          4: lead = 8'hf0 | 8'($urandom_range(0, 7));
          5: lead = 8'hf8 | 8'($urandom_range(0, 3));
          default: lead = 8'hfc | 8'($urandom_range(0, 1));
        endcase
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len) : len;
        for (int i = 0; i < cut; i++) begin
          b = (i == 0) ? lead : (8'h80 | 8'($urandom_range(0, 63)));
          add_word(b, ($urandom_range(0, 29) == 0),
                   (added == 0) || ($urandom_range(0, 119) == 0));
          added++;
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (text_q.size() != 0 || in_valid || unit_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d words pending, %0d units expected",
             text_q.size(), unit_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
